// File: rtl/ptw_pkg.sv
// Shared types, constants and sizes for the three-level page table walker.
`default_nettype none

package ptw_pkg;

    // Store geometry
    localparam int STORE_FRAMES    = 8;
    localparam int WORDS_PER_FRAME = 512;
    localparam int STORE_DEPTH     = STORE_FRAMES * WORDS_PER_FRAME;
    localparam int ADDR_W          = $clog2(STORE_DEPTH);

    // Field widths
    localparam int VA_W       = 39;
    localparam int IDX_W      = 9;
    localparam int OFFSET_W   = 12;
    localparam int ENTRY_W    = 12;
    localparam int DESC_W     = 64;
    localparam int FRAME_W    = 36;   // descriptor bits 47:12
    localparam int TOP_W      = 3;
    localparam int EXT_W      = ADDR_W + ENTRY_W;
    localparam int UNIT_W     = FRAME_W + IDX_W;

    // Descriptor encoding
    localparam logic [1:0] DESC_VALID = 2'b11;

    // Walk levels, counted from zero
    localparam logic [1:0] LEVEL_1    = 2'd0;
    localparam logic [1:0] LEVEL_2    = 2'd1;
    localparam logic [1:0] LEVEL_3    = 2'd2;

    // Item modes
    localparam logic MODE_TRANSLATE = 1'b0;
    localparam logic MODE_WRITE     = 1'b1;

    typedef enum logic [1:0] {
        S_CLEAR,
        S_IDLE,
        S_WALK,
        S_HOLD
    } ptw_state_t;

    typedef struct packed {
        logic                mode;
        logic [VA_W-1:0]     virt_addr;
        logic [ENTRY_W-1:0]  entry_index;
        logic [DESC_W-1:0]   entry_value;
    } ptw_in_t;

    typedef struct packed {
        logic [DESC_W-1:0]   result_value;
        logic                fault;
    } ptw_out_t;

endpackage

`default_nettype wire

// File: rtl/three_level_page_table_walker.sv
// Top level: three-level page table walker with a local descriptor store.
//
//  Channel   Ports                         Dir  Content
//  input     s_valid s_ready s_data        in   ptw_in_t: mode, va, entry index/value
//  result    m_valid m_ready m_data        out  ptw_out_t: result_value, fault
//  config    cfg_wr_en cfg_wr_data         in   top_table_frame, written at once
//
//  A write item needs no walk; a translation is accepted and then walks the three levels
//  in S_WALK, paced by the three dependent reads of the registered-read store.
//  A fault found early ends the walk at that level.
//  After reset a clearing pass zeroes all STORE_DEPTH (4096) words of the store, one word
//  a cycle, during which s_ready is low; config writes are still taken.
//  A finished result waits in a hold state while the output register is full.
`default_nettype none

module three_level_page_table_walker (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic              s_valid,
    output logic                   s_ready,
    input  wire ptw_pkg::ptw_in_t  s_data,
    output logic                   m_valid,
    input  wire logic              m_ready,
    output ptw_pkg::ptw_out_t      m_data,
    input  wire logic              cfg_wr_en,
    input  wire logic [2:0]        cfg_wr_data
);

    import ptw_pkg::*;

    ptw_state_t           state_reg, state_next;
    logic [1:0]           level_reg, level_next;
    logic [VA_W-1:0]      va_reg, va_next;
    logic [ADDR_W-1:0]    clr_cnt_reg, clr_cnt_next;
    logic [TOP_W-1:0]     top_frame_reg;
    logic [DESC_W-1:0]    res_val_reg, res_val_next;
    logic                 res_fault_reg, res_fault_next;
    logic                 m_valid_reg, m_valid_next;
    ptw_out_t             m_data_reg, m_data_next;

    // Store ports
    logic                 ram_wr_en;
    logic [ADDR_W-1:0]    ram_wr_addr;
    logic [DESC_W-1:0]    ram_wr_data;
    logic [ADDR_W-1:0]    ram_rd_addr;
    logic [DESC_W-1:0]    ram_rd_data;

    // Shared address/range unit
    logic [FRAME_W-1:0]   unit_frame;
    logic [1:0]           unit_level;
    logic [VA_W-1:0]      unit_va;
    logic [IDX_W-1:0]     unit_idx;
    logic [UNIT_W-1:0]    unit_wide;
    logic [ADDR_W-1:0]    unit_addr;
    logic                 unit_in_range;

    // Write-item address handling
    logic [EXT_W-1:0]     entry_ext;
    logic                 entry_in_range;

    // Completion request
    logic                 fin_req;
    logic [DESC_W-1:0]    fin_val;
    logic                 fin_fault;
    logic                 out_free;
    logic                 desc_ok;

    ptw_ram #(
        .WIDTH (DESC_W),
        .DEPTH (STORE_DEPTH)
    ) u_store (
        .aclk    (aclk),
        .wr_en   (ram_wr_en),
        .wr_addr (ram_wr_addr),
        .wr_data (ram_wr_data),
        .rd_addr (ram_rd_addr),
        .rd_data (ram_rd_data)
    );

    // Table index for the level being read
    always_comb begin
        unique case (unit_level)
            LEVEL_1: unit_idx = unit_va[38:30];
            LEVEL_2: unit_idx = unit_va[29:21];
            LEVEL_3: unit_idx = unit_va[20:12];
            default: unit_idx = '0;
        endcase
    end

    assign unit_wide     = {unit_frame, unit_idx};
    assign unit_addr     = unit_wide[ADDR_W-1:0];
    assign unit_in_range = unit_frame < FRAME_W'(STORE_FRAMES);

    assign entry_ext      = EXT_W'(s_data.entry_index);
    assign entry_in_range = 32'(s_data.entry_index) < 32'(STORE_DEPTH);

    assign desc_ok  = ram_rd_data[1:0] == DESC_VALID;
    assign out_free = !m_valid_reg || m_ready;

    // Sequencer: next state and datapath controls
    always_comb begin
        state_next     = state_reg;
        level_next     = level_reg;
        va_next        = va_reg;
        clr_cnt_next   = clr_cnt_reg;
        res_val_next   = res_val_reg;
        res_fault_next = res_fault_reg;
        m_valid_next   = m_valid_reg;
        m_data_next    = m_data_reg;
        s_ready        = 1'b0;
        ram_wr_en      = 1'b0;
        ram_wr_addr    = entry_ext[ADDR_W-1:0];
        ram_wr_data    = s_data.entry_value;
        ram_rd_addr    = unit_addr;
        unit_frame     = FRAME_W'(top_frame_reg);
        unit_level     = LEVEL_1;
        unit_va        = s_data.virt_addr;
        fin_req        = 1'b0;
        fin_val        = '0;
        fin_fault      = 1'b0;

        if (m_valid_reg && m_ready) begin
            m_valid_next = 1'b0;
        end

        unique case (state_reg)
            S_CLEAR: begin
                ram_wr_en    = 1'b1;
                ram_wr_addr  = clr_cnt_reg;
                ram_wr_data  = '0;
                clr_cnt_next = clr_cnt_reg + 1'b1;
                if (clr_cnt_reg == ADDR_W'(STORE_DEPTH - 1)) begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    if (s_data.mode == MODE_WRITE) begin
                        ram_wr_en = entry_in_range;
                        fin_req   = 1'b1;
                    end else begin
                        va_next = s_data.virt_addr;
                        if (unit_in_range) begin
                            level_next = LEVEL_1;
                            state_next = S_WALK;
                        end else begin
                            fin_req   = 1'b1;
                            fin_val   = '1;
                            fin_fault = 1'b1;
                        end
                    end
                end
            end
            S_WALK: begin
                unit_frame = ram_rd_data[47:12];
                unit_level = level_reg + 1'b1;
                unit_va    = va_reg;
                if (!desc_ok) begin
                    fin_req   = 1'b1;
                    fin_val   = '1;
                    fin_fault = 1'b1;
                end else if (level_reg == LEVEL_3) begin
                    fin_req = 1'b1;
                    fin_val = {16'b0, ram_rd_data[47:12], va_reg[OFFSET_W-1:0]};
                end else if (unit_in_range) begin
                    level_next = level_reg + 1'b1;
                end else begin
                    fin_req   = 1'b1;
                    fin_val   = '1;
                    fin_fault = 1'b1;
                end
            end
            S_HOLD: begin
                if (out_free) begin
                    m_valid_next = 1'b1;
                    m_data_next  = '{result_value: res_val_reg, fault: res_fault_reg};
                    state_next   = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase

        // Finish: straight to the output register, or park until it frees up
        if (fin_req) begin
            if (out_free) begin
                m_valid_next = 1'b1;
                m_data_next  = '{result_value: fin_val, fault: fin_fault};
                state_next   = S_IDLE;
            end else begin
                res_val_next   = fin_val;
                res_fault_next = fin_fault;
                state_next     = S_HOLD;
            end
        end
    end

    // Control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= S_CLEAR;
            clr_cnt_reg   <= '0;
            m_valid_reg   <= 1'b0;
            top_frame_reg <= '0;
        end else begin
            state_reg   <= state_next;
            clr_cnt_reg <= clr_cnt_next;
            m_valid_reg <= m_valid_next;
            if (cfg_wr_en) begin
                top_frame_reg <= cfg_wr_data;
            end
        end
    end

    // Payload registers
    always_ff @(posedge aclk) begin
        level_reg     <= level_next;
        va_reg        <= va_next;
        res_val_reg   <= res_val_next;
        res_fault_reg <= res_fault_next;
        m_data_reg    <= m_data_next;
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

    // No store write may land while a walk is reading it
    a_no_write_in_walk: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == S_WALK |-> !ram_wr_en)
        else $error("store written during a walk");

    // A translation with an in-range top table starts its walk at level 1
    a_walk_start: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready && s_data.mode == MODE_TRANSLATE && unit_in_range)
        |=> (state_reg == S_WALK && level_reg == LEVEL_1))
        else $error("walk did not start at level 1");

    // The level counter stays within the three levels
    a_level_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == S_WALK |-> (level_reg == LEVEL_1 || level_reg == LEVEL_2 ||
                                 level_reg == LEVEL_3))
        else $error("walk level out of range");

    // A parked result only exists while the output register is occupied
    a_hold_full: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == S_HOLD |-> m_valid_reg)
        else $error("result parked with empty output register");

    // A fault always carries the all-ones value
    a_fault_value: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid_reg && m_data_reg.fault) |-> (&m_data_reg.result_value))
        else $error("fault without all-ones result");

endmodule

`default_nettype wire

// File: rtl/ptw_ram.sv
// Generic single-write, single-read RAM with registered read data.
`default_nettype none

module ptw_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 4096
) (
    input  wire logic                     aclk,
    input  wire logic                     wr_en,
    input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
    input  wire logic [WIDTH-1:0]         wr_data,
    input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic      [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write port and registered read port
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        rd_data <= mem[rd_addr];
    end

endmodule

`default_nettype wire

// File: verif/testbench.sv
// Testbench for the three-level page table walker: mixed descriptor writes and walks.
`timescale 1ns / 1ps

module testbench;
    import ptw_pkg::*;

    localparam int RUN_LIMIT   = 300000;
    localparam int HOLD_CYCLES = 400;
    localparam int PHASE_ITEMS = 200;
    localparam int DRAIN_WAIT  = 12;

    logic              aclk        = 1'b0;
    logic              aresetn     = 1'b0;
    logic              s_valid     = 1'b0;
    logic              s_ready;
    ptw_in_t           s_data      = '0;
    logic              m_valid;
    logic              m_ready     = 1'b0;
    ptw_out_t          m_data;
    logic              cfg_wr_en   = 1'b0;
    logic [2:0]        cfg_wr_data = 3'd0;

    // Model state: descriptor words and the top-level table frame
    logic [DESC_W-1:0] desc_mem [STORE_DEPTH];
    logic [TOP_W-1:0]  top_frame = '0;

    ptw_in_t           xlat_requests[$];
    ptw_out_t          predicted_results[$];
    logic [VA_W-1:0]   mapped_vas[$];
    ptw_out_t          want;

    int                sent_count  = 0;
    int                taken_count = 0;
    int                fail_count  = 0;
    int                cycle_count = 0;
    int                hold_left   = 0;
    bit                hold_req    = 1'b0;
    bit                steady      = 1'b0;
    bit                src_took    = 1'b0;

    three_level_page_table_walker dut (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_data      (s_data),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_data      (m_data),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data)
    );

    always begin
        #1 aclk = 1'b1;
        #1 aclk = 1'b0;
    end

    // Walk the model tables for one request; writes update the model store
    function automatic ptw_out_t walk_tables(ptw_in_t req);
        ptw_out_t          r;
        logic [DESC_W-1:0] d;
        logic [FRAME_W-1:0] frame;
        logic [IDX_W-1:0]  idx;
        bit                ok;
        r.result_value = '0;
        r.fault        = 1'b0;
        d              = '0;
        ok             = 1'b1;
        if (req.mode == MODE_WRITE) begin
            if (int'(req.entry_index) < STORE_DEPTH)
                desc_mem[req.entry_index] = req.entry_value;
            return r;
        end
        frame = FRAME_W'(top_frame);
        for (int lvl = 0; lvl < 3; lvl++) begin
            if (ok) begin
                idx = req.virt_addr[38 - 9*lvl -: 9];
                if (frame >= FRAME_W'(STORE_FRAMES)) begin
                    ok = 1'b0;
                end else begin
                    d = desc_mem[int'(frame) * WORDS_PER_FRAME + int'(idx)];
                    if (d[1:0] != DESC_VALID)
                        ok = 1'b0;
                    else
                        frame = d[47:12];
                end
            end
        end
        if (ok) begin
            r.result_value = {16'd0, d[47:12], req.virt_addr[11:0]};
        end else begin
            r.result_value = '1;
            r.fault        = 1'b1;
        end
        return r;
    endfunction

    task automatic note_mismatch(string what, logic [63:0] got, logic [63:0] exp_val);
        fail_count++;
        $display("MISMATCH @%0d: %s got %h want %h", cycle_count, what, got, exp_val);
    endtask

    function automatic logic [63:0] rand64();
        return {$urandom, $urandom};
    endfunction

    function automatic logic [VA_W-1:0] rand_va();
        logic [63:0] t;
        t = rand64();
        return t[VA_W-1:0];
    endfunction

    // Descriptor with random don't-care bits around the frame and type bits
    function automatic logic [63:0] make_desc(logic [FRAME_W-1:0] frame, logic [1:0] low);
        logic [63:0] d;
        d        = rand64();
        d[47:12] = frame;
        d[1:0]   = low;
        return d;
    endfunction

    task automatic queue_store(logic [ENTRY_W-1:0] ix, logic [63:0] v);
        ptw_in_t r;
        r.mode        = MODE_WRITE;
        r.virt_addr   = rand_va();
        r.entry_index = ix;
        r.entry_value = v;
        xlat_requests.push_back(r);
        sent_count++;
    endtask

    task automatic queue_xlat(logic [VA_W-1:0] va);
        ptw_in_t r;
        r.mode        = MODE_TRANSLATE;
        r.virt_addr   = va;
        r.entry_index = ENTRY_W'($urandom);
        r.entry_value = rand64();
        xlat_requests.push_back(r);
        sent_count++;
    endtask

    // Build a three-level mapping for a random address, sometimes broken, then walk it
    task automatic map_and_walk(output int n);
        logic [VA_W-1:0]    va;
        logic [FRAME_W-1:0] nxt [3];
        logic [1:0]         low [3];
        int                 bad_lvl;
        int                 walks;
        va      = rand_va();
        nxt[0]  = FRAME_W'($urandom_range(0, STORE_FRAMES - 1));
        nxt[1]  = FRAME_W'($urandom_range(0, STORE_FRAMES - 1));
        nxt[2]  = FRAME_W'(rand64());
        low[0]  = DESC_VALID;
        low[1]  = DESC_VALID;
        low[2]  = DESC_VALID;
        bad_lvl = ($urandom_range(0, 4) == 0) ? $urandom_range(0, 2) : 3;
        if (bad_lvl < 3) begin
            if (bad_lvl < 2 && $urandom_range(0, 1)) begin
                nxt[bad_lvl]    = FRAME_W'(rand64());
                nxt[bad_lvl][3] = 1'b1;   // frame beyond the store
            end else begin
                low[bad_lvl] = 2'($urandom_range(0, 2));
            end
        end
        queue_store({top_frame, va[38:30]}, make_desc(nxt[0], low[0]));
        queue_store({nxt[0][2:0], va[29:21]}, make_desc(nxt[1], low[1]));
        queue_store({nxt[1][2:0], va[20:12]}, make_desc(nxt[2], low[2]));
        walks = $urandom_range(1, 3);
        for (int k = 0; k < walks; k++) begin
            va[11:0] = 12'($urandom);
            queue_xlat(va);
        end
        mapped_vas.push_back(va);
        if (mapped_vas.size() > 16)
            void'(mapped_vas.pop_front());
        n = 3 + walks;
    endtask

    task automatic queue_random_phase(int count);
        int done;
        int n;
        int pick;
        logic [VA_W-1:0] va;
        done = 0;
        while (done < count) begin
            pick = $urandom_range(0, 99);
            if (pick < 65) begin
                map_and_walk(n);
                done += n;
            end else if (pick < 85) begin
                if (mapped_vas.size() > 0 && $urandom_range(0, 1)) begin
                    va       = mapped_vas[$urandom_range(0, mapped_vas.size() - 1)];
                    va[11:0] = 12'($urandom);
                end else begin
                    va = rand_va();
                end
                queue_xlat(va);
                done++;
            end else begin
                queue_store(ENTRY_W'($urandom), rand64());
                done++;
            end
        end
    endtask

    task automatic wait_drained();
        while (taken_count != sent_count || predicted_results.size() != 0)
            @(negedge aclk);
    endtask

    task automatic set_top_frame(logic [TOP_W-1:0] v);
        @(negedge aclk);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= v;
        top_frame    = v;
        @(negedge aclk);
        cfg_wr_en   <= 1'b0;
    endtask

    // Input driver: offers queued requests at the falling edge
    always @(negedge aclk) begin
        if (!aresetn) begin
            s_valid <= 1'b0;
        end else if (!s_valid || src_took) begin
            if (xlat_requests.size() > 0 && (steady || $urandom_range(0, 99) >= 20)) begin
                s_data  <= xlat_requests.pop_front();
                s_valid <= 1'b1;
            end else begin
                s_valid <= 1'b0;
            end
        end
    end

    // Result side backpressure, with an occasional long hold-off
    always @(negedge aclk) begin
        if (hold_req) begin
            hold_left = HOLD_CYCLES;
            hold_req  = 1'b0;
        end
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else if (hold_left > 0) begin
            m_ready <= 1'b0;
            hold_left--;
        end else begin
            m_ready <= steady || $urandom_range(0, 99) >= 20;
        end
    end

    // Monitor: predict on each input transfer, check each result transfer
    always @(posedge aclk) begin
        src_took = aresetn && s_valid && s_ready;
        if (src_took) begin
            predicted_results.push_back(walk_tables(s_data));
            taken_count++;
        end
        if (aresetn && m_valid && m_ready) begin
            if (predicted_results.size() == 0) begin
                note_mismatch("result with nothing pending", m_data.result_value, '0);
            end else begin
                want = predicted_results.pop_front();
                if (m_data.result_value !== want.result_value)
                    note_mismatch("result_value", m_data.result_value, want.result_value);
                if (m_data.fault !== want.fault)
                    note_mismatch("fault", 64'(m_data.fault), 64'(want.fault));
            end
        end
    end

    // Watchdog
    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count >= RUN_LIMIT) begin
            $display("timeout after %0d cycles", cycle_count);
            $display("three_level_page_table_walker verification failed");
            $finish;
        end
    end

    initial begin
        logic [TOP_W-1:0] phase_top [5];
        for (int i = 0; i < STORE_DEPTH; i++)
            desc_mem[i] = '0;
        phase_top[0] = 3'd7;
        phase_top[1] = 3'($urandom_range(1, 6));
        phase_top[2] = 3'd0;
        phase_top[3] = 3'($urandom_range(0, 7));
        phase_top[4] = 3'd7;

        repeat (11) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        // register write lands during the store clearing pass
        set_top_frame(3'd0);

        // Directed: fault kinds, extreme fields, walk through one page
        queue_xlat('0);                                    // empty top-level entry
        queue_store(12'd0, make_desc(36'd1, 2'b01));       // block pattern at level 1
        queue_xlat('0);
        queue_store(12'd0, make_desc(36'd1, DESC_VALID));
        queue_store(12'd512, make_desc(36'd2, 2'b00));     // invalid at level 2
        queue_xlat('0);
        queue_store(12'd512, make_desc(36'd2, 2'b10));
        queue_xlat('0);
        queue_store(12'd512, make_desc(36'd2, DESC_VALID));
        queue_store(12'd1024, '1);                          // page frame all ones
        queue_xlat(39'hFFF);
        queue_store(12'd1024, make_desc(36'd0, DESC_VALID));
        queue_xlat(39'h123);
        queue_store(12'd512, make_desc(36'd8, DESC_VALID)); // level-3 table off the store
        queue_xlat('0);
        queue_store(12'd511, 64'hFFFF_0000_0000_7FFF);      // highest frame and index
        queue_store(12'd4095, 64'hFFFF_0000_0000_7FFF);
        queue_xlat('1);
        queue_store(12'd1, '1);                             // level-2 table off the store
        queue_xlat(39'h00_4000_0000);
        queue_store(12'd4095, '1);
        queue_xlat('1);
        wait_drained();

        // Random phases over several top-table settings
        for (int p = 0; p < 5; p++) begin
            repeat (DRAIN_WAIT) @(negedge aclk);
            set_top_frame(phase_top[p]);
            @(posedge aclk);
            steady   = (p == 2);
            hold_req = (p == 1);
            queue_random_phase(PHASE_ITEMS);
            wait_drained();
        end

        repeat (DRAIN_WAIT) @(posedge aclk);
        if (predicted_results.size() != 0)
            note_mismatch("results never returned", 64'(predicted_results.size()), '0);
        if (fail_count == 0) begin
            $display("three_level_page_table_walker verification clean");
        end else begin
            $display("three_level_page_table_walker verification failed");
        end
        $finish;
    end

endmodule
